// ----- rtl/core/blg_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery level gauge package
// Shared widths, configuration register layout and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package blg_pkg;

	localparam int CODE_W        = 12;
	localparam int LEVEL_W       = 3;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 4;
	localparam int AVG_DEPTH_DEF = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;

	localparam logic [CODE_W-1:0] EMPTY_RST  = 12'd1158;
	localparam logic [CODE_W-1:0] STEP_RST   = 12'd145;
	localparam logic [CODE_W-1:0] MARGIN_RST = 12'd36;

	localparam logic [1:0] REG_EMPTY  = 2'd0;
	localparam logic [1:0] REG_STEP   = 2'd1;
	localparam logic [1:0] REG_MARGIN = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0] empty_code;
		logic [CODE_W-1:0] step_code;
		logic [CODE_W-1:0] margin_code;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/blg_regs.sv -----
// ----------------------------------------------------------------------------
// Battery level gauge configuration registers
// APB-style register bank holding the empty, step and margin codes.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [blg_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [blg_pkg::DATA_W-1:0]   pwdata,
	output logic      [blg_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	output blg_pkg::cfg_t                     cfg
);

	blg_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;
	logic [blg_pkg::CODE_W-1:0] rd_val;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.empty_code  <= blg_pkg::EMPTY_RST;
			cfg_q.step_code   <= blg_pkg::STEP_RST;
			cfg_q.margin_code <= blg_pkg::MARGIN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				blg_pkg::REG_EMPTY:  cfg_q.empty_code  <= pwdata[blg_pkg::CODE_W-1:0];
				blg_pkg::REG_STEP:   cfg_q.step_code   <= pwdata[blg_pkg::CODE_W-1:0];
				blg_pkg::REG_MARGIN: cfg_q.margin_code <= pwdata[blg_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			blg_pkg::REG_EMPTY:  rd_val = cfg_q.empty_code;
			blg_pkg::REG_STEP:   rd_val = cfg_q.step_code;
			blg_pkg::REG_MARGIN: rd_val = cfg_q.margin_code;
			default:             rd_val = '0;
		endcase
	end

	assign prdata = blg_pkg::DATA_W'(rd_val);

endmodule

`default_nettype wire

// ----- rtl/core/blg_ring.sv -----
// ----------------------------------------------------------------------------
// Battery level gauge sample ring
// Ring memory of recent codes with pointer, priming logic and running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_ring #(
	parameter int AVG_DEPTH = blg_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           en,
	input  wire logic [blg_pkg::CODE_W-1:0]                     code,
	output logic [blg_pkg::CODE_W+$clog2(AVG_DEPTH)-1:0]        sum_next,
	output logic [blg_pkg::CODE_W+$clog2(AVG_DEPTH)-1:0]        sum
);

	localparam int PTR_W = $clog2(AVG_DEPTH);
	localparam int SUM_W = blg_pkg::CODE_W + PTR_W;
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(AVG_DEPTH - 1);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(AVG_DEPTH);

	logic [blg_pkg::CODE_W-1:0] ring_mem [AVG_DEPTH];
	logic [blg_pkg::CODE_W-1:0] rd_q;
	logic [blg_pkg::CODE_W-1:0] first_q;
	logic [blg_pkg::CODE_W-1:0] old_code;
	logic [PTR_W-1:0]           ptr_q;
	logic [PTR_W-1:0]           ptr_nx;
	logic [PTR_W-1:0]           rd_addr;
	logic [SUM_W-1:0]           sum_q;
	logic                       primed_q;
	logic                       wrapped_q;

	// Until the pointer has gone round once, every slot it reaches counts as
	// holding the priming sample.
	assign old_code = wrapped_q ? rd_q : first_q;

	always_comb begin
		if (primed_q) begin
			sum_next = sum_q - SUM_W'(old_code) + SUM_W'(code);
			ptr_nx   = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
		end else begin
			sum_next = SUM_W'(code) * DEPTH_SUM;
			ptr_nx   = PTR_W'(1);
		end
	end

	assign rd_addr = en ? ptr_nx : ptr_q;
	assign sum     = sum_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ring_mem[ptr_q] <= code;
		end
		rd_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (en && !primed_q) begin
			first_q <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			sum_q     <= '0;
			primed_q  <= 1'b0;
			wrapped_q <= 1'b0;
		end else if (en) begin
			ptr_q    <= ptr_nx;
			sum_q    <= sum_next;
			primed_q <= 1'b1;
			if (primed_q && ptr_q == PTR_LAST) begin
				wrapped_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/blg_level.sv -----
// ----------------------------------------------------------------------------
// Battery level gauge hysteresis
// Compares the running sum with depth-scaled thresholds and steps the level.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_level #(
	parameter int AVG_DEPTH = blg_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       en,
	input  wire blg_pkg::cfg_t                              cfg,
	input  wire logic [blg_pkg::CODE_W+$clog2(AVG_DEPTH)-1:0] sum_next,
	output logic [blg_pkg::LEVEL_W-1:0]                     level
);

	localparam int BASE_W = blg_pkg::CODE_W + 3;
	localparam int THR_W  = BASE_W + $clog2(AVG_DEPTH + 1);
	localparam logic [THR_W-1:0] DEPTH_THR = THR_W'(AVG_DEPTH);

	logic [blg_pkg::LEVEL_W-1:0] level_q;
	logic [blg_pkg::LEVEL_W-1:0] level_d;
	logic [BASE_W-1:0] up_base;
	logic [BASE_W-1:0] dn_pos;
	logic [BASE_W-1:0] dn_base;
	logic              dn_neg;
	logic [THR_W-1:0]  up_thr;
	logic [THR_W-1:0]  dn_thr;
	logic [THR_W-1:0]  sum_ext;
	logic              go_up;
	logic              go_dn;

	function automatic logic [BASE_W-1:0] step_times(
		input logic [blg_pkg::CODE_W-1:0] step,
		input logic [2:0]                 k
	);
		logic [BASE_W-1:0] s;
		s = BASE_W'(step);
		return (k[2] ? (s << 2) : '0) + (k[1] ? (s << 1) : '0) + (k[0] ? s : '0);
	endfunction

	always_comb begin
		up_base = BASE_W'(cfg.empty_code) + step_times(cfg.step_code, level_q + 3'd1)
		          + BASE_W'(cfg.margin_code);
		dn_pos  = BASE_W'(cfg.empty_code) + step_times(cfg.step_code, level_q);
		dn_neg  = dn_pos < BASE_W'(cfg.margin_code);
		dn_base = dn_pos - BASE_W'(cfg.margin_code);
		up_thr  = THR_W'(up_base) * DEPTH_THR;
		dn_thr  = THR_W'(dn_base) * DEPTH_THR;
		sum_ext = THR_W'(sum_next);
		go_up   = sum_ext > up_thr;
		go_dn   = !dn_neg && (sum_ext < dn_thr);
		if (go_up) begin
			level_d = (level_q >= blg_pkg::LEVEL_MAX) ? blg_pkg::LEVEL_MAX : level_q + 3'd1;
		end else if (go_dn) begin
			level_d = (level_q == '0) ? '0 : level_q - 3'd1;
		end else begin
			level_d = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (en) begin
			level_q <= level_d;
		end
	end

	assign level = level_q;

endmodule

`default_nettype wire

// ----- rtl/core/blg_avg.sv -----
// ----------------------------------------------------------------------------
// Battery level gauge result stage
// Divides the running sum by the depth with a reciprocal multiply and holds
// the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_avg #(
	parameter int AVG_DEPTH = blg_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         en,
	input  wire logic                                         valid_s2,
	input  wire logic [blg_pkg::CODE_W+$clog2(AVG_DEPTH)-1:0] sum_s2,
	input  wire logic [blg_pkg::LEVEL_W-1:0]                  level_s2,
	output logic                                              valid_s3,
	output logic [blg_pkg::LEVEL_W-1:0]                       level_s3,
	output logic [blg_pkg::CODE_W-1:0]                        average_s3
);

	localparam int DIV_L   = $clog2(AVG_DEPTH);
	localparam int SUM_W   = blg_pkg::CODE_W + DIV_L;
	localparam int DIV_K   = SUM_W + DIV_L;
	localparam int RECIP   = (2 ** DIV_K + AVG_DEPTH - 1) / AVG_DEPTH;
	localparam int RECIP_W = DIV_K - DIV_L + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic [PROD_W-1:0]          product;
	logic [blg_pkg::CODE_W-1:0] quotient;

	assign product  = PROD_W'(sum_s2) * PROD_W'(RECIP);
	assign quotient = product[DIV_K +: blg_pkg::CODE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s3   <= level_s2;
			average_s3 <= quotient;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/battery_level_hysteresis_gauge.sv -----
// ----------------------------------------------------------------------------
// Battery level hysteresis gauge
// Moving average of supply ADC codes with a hysteresis level from 0 to 4.
//
//   Channel   Signals                                   Direction
//   sample    sample_valid, sample_ready, sample_code    in
//   result    result_valid, result_ready, level,         out
//             average_code
//   config    psel, penable, pwrite, paddr, pwdata,      in / out
//             prdata, pready
//
// One sample transfer can be taken every cycle unless the pipeline holds. A
// result is presented after its sample passes three registers in order: input
// register, sum and level update, divide and result register. When a result
// waits and result_ready is low, the whole pipeline holds and sample_ready
// drops. Reset clears control state at once; there is no clearing pass, since
// the first sample primes the whole ring.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_hysteresis_gauge #(
	parameter int AVG_DEPTH = blg_pkg::AVG_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire logic [blg_pkg::CODE_W-1:0]      sample_code,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [blg_pkg::LEVEL_W-1:0]          level,
	output logic [blg_pkg::CODE_W-1:0]           average_code,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [blg_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [blg_pkg::DATA_W-1:0]      pwdata,
	output logic      [blg_pkg::DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int SUM_W = blg_pkg::CODE_W + $clog2(AVG_DEPTH);

	blg_pkg::cfg_t              cfg;
	logic                       advance;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       en_s2;
	logic [blg_pkg::CODE_W-1:0] sample_s1;
	logic [SUM_W-1:0]           sum_next;
	logic [SUM_W-1:0]           sum_s2;
	logic [blg_pkg::LEVEL_W-1:0] level_s2;

	assign advance      = !result_valid || result_ready;
	assign sample_ready = advance;
	assign en_s2        = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample_code;
		end
	end

	blg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	blg_ring #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s2),
		.code     (sample_s1),
		.sum_next (sum_next),
		.sum      (sum_s2)
	);

	blg_level #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s2),
		.cfg      (cfg),
		.sum_next (sum_next),
		.level    (level_s2)
	);

	blg_avg #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.valid_s2   (valid_s2),
		.sum_s2     (sum_s2),
		.level_s2   (level_s2),
		.valid_s3   (result_valid),
		.level_s3   (level),
		.average_s3 (average_code)
	);

endmodule

`default_nettype wire
